FILE: src/lpfs_pkg.sv
// shared constants and types for the length-prefixed frame splitter
`timescale 1ns / 1ps

package lpfs_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int HEADER_BYTES        = 4;
    localparam int BYTE_W              = 8;
    localparam int CFG_W               = 13;
    localparam int LEN_W               = 32;
    localparam int POS_OUT_W           = 12;

    localparam logic [CFG_W-1:0] CFG_MAX_RESET = 13'd4096;

    typedef struct packed {
        logic [BYTE_W-1:0]    frame_byte;
        logic [POS_OUT_W-1:0] byte_position;
        logic                 frame_start;
        logic                 frame_last;
        logic                 length_error;
        logic [LEN_W-1:0]     declared_length;
    } result_t;

endpackage

FILE: src/lpfs_cfg_reg.sv
// maximum frame length register and clamped effective maximum
`timescale 1ns / 1ps

module lpfs_cfg_reg #(
    parameter int MAX_FRAME_BYTES = lpfs_pkg::MAX_FRAME_BYTES_DEF,
    parameter int EMAX_W = (($clog2(MAX_FRAME_BYTES + 1) > lpfs_pkg::CFG_W)
                           ? $clog2(MAX_FRAME_BYTES + 1) : lpfs_pkg::CFG_W)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lpfs_pkg::CFG_W-1:0] cfg_wr_data,
    output logic [EMAX_W-1:0]          eff_max
);

    localparam logic [EMAX_W-1:0] PARAM_MAX = EMAX_W'(MAX_FRAME_BYTES);
    localparam logic [EMAX_W-1:0] RESET_EXT = EMAX_W'(lpfs_pkg::CFG_MAX_RESET);
    localparam logic [EMAX_W-1:0] EFF_RESET = (RESET_EXT > PARAM_MAX) ? PARAM_MAX : RESET_EXT;

    logic [lpfs_pkg::CFG_W-1:0] max_len_reg;
    logic [EMAX_W-1:0]          eff_max_reg;
    logic [EMAX_W-1:0]          eff_max_next;
    logic [EMAX_W-1:0]          cfg_ext;

    assign cfg_ext      = EMAX_W'(max_len_reg);
    assign eff_max_next = (cfg_ext > PARAM_MAX) ? PARAM_MAX : cfg_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= lpfs_pkg::CFG_MAX_RESET;
            eff_max_reg <= EFF_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            eff_max_reg <= eff_max_next;
        end
    end

    assign eff_max = eff_max_reg;

endmodule

FILE: src/lpfs_in_stage.sv
// input register stage for the byte stream
`timescale 1ns / 1ps

module lpfs_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0] data_byte,
    input  logic                        advance,
    output logic                        s1_valid,
    output logic [lpfs_pkg::BYTE_W-1:0] s1_byte
);

    logic                        valid_reg;
    logic [lpfs_pkg::BYTE_W-1:0] byte_reg;

    // stage frees up when the next stage takes its byte
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= data_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

FILE: src/lpfs_deframer.sv
// frame position and length tracking with result register
`timescale 1ns / 1ps

module lpfs_deframer #(
    parameter int MAX_FRAME_BYTES = lpfs_pkg::MAX_FRAME_BYTES_DEF,
    parameter int EMAX_W = (($clog2(MAX_FRAME_BYTES + 1) > lpfs_pkg::CFG_W)
                           ? $clog2(MAX_FRAME_BYTES + 1) : lpfs_pkg::CFG_W)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    input  logic [lpfs_pkg::BYTE_W-1:0] s1_byte,
    output logic                        advance,
    input  logic [EMAX_W-1:0]           eff_max,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lpfs_pkg::result_t           result
);

    localparam int POS_W = (($clog2(MAX_FRAME_BYTES) > lpfs_pkg::POS_OUT_W)
                           ? $clog2(MAX_FRAME_BYTES) : lpfs_pkg::POS_OUT_W);
    localparam int LEN_W = lpfs_pkg::LEN_W;
    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(lpfs_pkg::HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_LEN  = POS_W'(lpfs_pkg::HEADER_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN32 = LEN_W'(lpfs_pkg::HEADER_BYTES);

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [LEN_W-1:0]     acc_reg;
    logic [LEN_W-1:0]     acc_next;
    logic                 out_valid_reg;
    lpfs_pkg::result_t    result_reg;
    lpfs_pkg::result_t    result_next;
    logic [LEN_W-1:0]     byte_ext;
    logic [LEN_W-1:0]     pos_inc;
    logic                 is_header;
    logic                 last;
    logic                 err;

    assign advance  = !out_valid_reg || !out_stall;
    assign byte_ext = LEN_W'(s1_byte);
    assign pos_inc  = LEN_W'(pos_reg) + LEN_W'(1);
    assign is_header = (pos_reg < HDR_LEN);

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg + POS_W'(1);
        last     = 1'b0;
        err      = 1'b0;
        if (is_header)
        begin
            case (pos_reg[1:0])
                2'd0:    acc_next = byte_ext;
                2'd1:    acc_next = acc_reg | (byte_ext << 8);
                2'd2:    acc_next = acc_reg | (byte_ext << 16);
                2'd3:    acc_next = acc_reg | (byte_ext << 24);
                default: acc_next = acc_reg;
            endcase
            if (pos_reg == HDR_LAST)
            begin
                if ((acc_next < HDR_LEN32) || (acc_next > LEN_W'(eff_max)))
                begin
                    err  = 1'b1;
                    last = 1'b1;
                end
                else if (acc_next == HDR_LEN32)
                begin
                    last = 1'b1;
                end
            end
        end
        else if (pos_inc >= acc_reg)
        begin
            last = 1'b1;
        end
        if (last)
        begin
            pos_next = '0;
        end

        result_next.frame_byte      = s1_byte;
        result_next.byte_position   = pos_reg[lpfs_pkg::POS_OUT_W-1:0];
        result_next.frame_start     = (pos_reg == '0);
        result_next.frame_last      = last;
        result_next.length_error    = err;
        result_next.declared_length = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid;
            if (s1_valid)
            begin
                pos_reg <= pos_next;
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: src/length_prefixed_frame_splitter.sv
// top level of the length-prefixed frame splitter
`timescale 1ns / 1ps

// splits a byte stream into frames that begin with a 4-byte little-endian
// total length (header included); each byte comes out with its position,
// first and last marks, an error mark and the length assembled so far
// input channel: in_valid / in_stall with data_byte, one byte per transfer
// output channel: out_valid / out_stall with one result per input byte
// config: cfg_wr_en / cfg_wr_data set the largest allowed frame length,
// clamped to MAX_FRAME_BYTES; write only while the block is idle
// path: an accepted byte waits in the input register, and its result is
// then registered in the result register, which drives out_valid
// throughput: one byte per cycle while out_stall is low; the position and
// length update from input register to result register is combinational
// a frame of length 4 ends on its last header byte; a length below 4 or
// above the maximum is flagged on the last header byte and ends the frame
// reset: position and length clear, next byte is header byte 0, maximum 4096
// when out_stall is high the result holds, the input register holds one
// more byte, and in_stall rises only once both are full

module length_prefixed_frame_splitter #(
    parameter int MAX_FRAME_BYTES = lpfs_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpfs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0]    data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lpfs_pkg::BYTE_W-1:0]    frame_byte,
    output logic [lpfs_pkg::POS_OUT_W-1:0] byte_position,
    output logic                           frame_start,
    output logic                           frame_last,
    output logic                           length_error,
    output logic [lpfs_pkg::LEN_W-1:0]     declared_length
);

    localparam int EMAX_W = (($clog2(MAX_FRAME_BYTES + 1) > lpfs_pkg::CFG_W)
                            ? $clog2(MAX_FRAME_BYTES + 1) : lpfs_pkg::CFG_W);

    logic [EMAX_W-1:0]           eff_max;
    logic                        s1_valid;
    logic [lpfs_pkg::BYTE_W-1:0] s1_byte;
    logic                        advance;
    lpfs_pkg::result_t           result;

    lpfs_cfg_reg #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .EMAX_W          (EMAX_W)
    ) u_cfg_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .eff_max     (eff_max)
    );

    lpfs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte)
    );

    lpfs_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .EMAX_W          (EMAX_W)
    ) u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte),
        .advance   (advance),
        .eff_max   (eff_max),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign frame_byte      = result.frame_byte;
    assign byte_position   = result.byte_position;
    assign frame_start     = result.frame_start;
    assign frame_last      = result.frame_last;
    assign length_error    = result.length_error;
    assign declared_length = result.declared_length;

endmodule

FILE: tb/sv/lpfs_frame_checker.sv
// checker for the frame splitter: predicts each output byte and compares it on the output channel
`timescale 1ns / 1ps

module lpfs_frame_checker #(
    parameter int MAX_FRAME_BYTES = lpfs_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpfs_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0]    frame_byte,
    input  logic [lpfs_pkg::POS_OUT_W-1:0] byte_position,
    input  logic                           frame_start,
    input  logic                           frame_last,
    input  logic                           length_error,
    input  logic [lpfs_pkg::LEN_W-1:0]     declared_length,
    output int                             mismatch_count,
    output int                             pending_count,
    output int                             bytes_checked,
    output int                             frames_closed,
    output int                             length_errors_seen
);

    lpfs_pkg::result_t predicted_bytes[$];

    int unsigned                  position;
    logic [lpfs_pkg::LEN_W-1:0]   accumulator;
    logic [lpfs_pkg::CFG_W-1:0]   limit_reg;

    function automatic lpfs_pkg::result_t split_byte(input logic [lpfs_pkg::BYTE_W-1:0] b);
        lpfs_pkg::result_t r;
        int unsigned       eff;
        int unsigned       nxt;
        eff = (limit_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : limit_reg;
        r.frame_byte    = b;
        r.byte_position = position[lpfs_pkg::POS_OUT_W-1:0];
        r.frame_start   = (position == 0);
        r.frame_last    = 1'b0;
        r.length_error  = 1'b0;
        nxt = position + 1;
        if (position < lpfs_pkg::HEADER_BYTES)
        begin
            if (position == 0)
                accumulator = {24'd0, b};
            else
                accumulator[8*position +: 8] = b;
            if (position == lpfs_pkg::HEADER_BYTES - 1)
            begin
                if (accumulator < lpfs_pkg::HEADER_BYTES || accumulator > eff)
                begin
                    r.length_error = 1'b1;
                    r.frame_last   = 1'b1;
                    nxt = 0;
                end
                else if (accumulator == lpfs_pkg::HEADER_BYTES)
                begin
                    r.frame_last = 1'b1;
                    nxt = 0;
                end
            end
        end
        else if (position + 1 >= accumulator)
        begin
            r.frame_last = 1'b1;
            nxt = 0;
        end
        r.declared_length = accumulator;
        position = nxt;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lpfs_pkg::result_t want;
        if (!rst_n)
        begin
            position           = 0;
            accumulator        = '0;
            limit_reg          = lpfs_pkg::CFG_MAX_RESET;
            predicted_bytes.delete();
            pending_count      = 0;
            mismatch_count     = 0;
            bytes_checked      = 0;
            frames_closed      = 0;
            length_errors_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_bytes.size() == 0)
                begin
                    $error("output transfer with no byte outstanding: frame_byte %0h",
                           frame_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_bytes.pop_front();
                    check_field("frame_byte", want.frame_byte, frame_byte);
                    check_field("byte_position", want.byte_position, byte_position);
                    check_field("frame_start", want.frame_start, frame_start);
                    check_field("frame_last", want.frame_last, frame_last);
                    check_field("length_error", want.length_error, length_error);
                    check_field("declared_length", want.declared_length, declared_length);
                    bytes_checked++;
                    if (want.frame_last)
                        frames_closed++;
                    if (want.length_error)
                        length_errors_seen++;
                end
            end
            if (cfg_wr_en)
                limit_reg = cfg_wr_data;
            if (in_valid && !in_stall)
                predicted_bytes.insert(predicted_bytes.size(), split_byte(data_byte));
            pending_count = predicted_bytes.size();
        end
    end

endmodule

FILE: tb/sv/tb_length_prefixed_frame_splitter.sv
// testbench top for the frame splitter: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_length_prefixed_frame_splitter;

    localparam int MAX_BYTES      = lpfs_pkg::MAX_FRAME_BYTES_DEF;
    localparam int PHASE_ITEMS    = 160;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_PERIOD    = 2500;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
    typedef enum int {FRAME_GOOD, FRAME_BAD_LENGTH, FRAME_WILD_LENGTH, FRAME_NOISE} frame_kind_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [lpfs_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [lpfs_pkg::BYTE_W-1:0]    data_byte;
    logic                           out_valid;
    logic                           out_stall;
    logic [lpfs_pkg::BYTE_W-1:0]    frame_byte;
    logic [lpfs_pkg::POS_OUT_W-1:0] byte_position;
    logic                           frame_start;
    logic                           frame_last;
    logic                           length_error;
    logic [lpfs_pkg::LEN_W-1:0]     declared_length;

    int mismatch_count;
    int pending_count;
    int bytes_checked;
    int frames_closed;
    int length_errors_seen;

    int burst_left;
    int items_sent;
    int eff_max;
    int cfg_writes;
    int idle_cycles;

    int       rx_cycle;
    int       hold_left;
    int       mode_left;
    rx_mode_t rx_mode;

    always #5 clk = ~clk;

    length_prefixed_frame_splitter #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .byte_position  (byte_position),
        .frame_start    (frame_start),
        .frame_last     (frame_last),
        .length_error   (length_error),
        .declared_length(declared_length)
    );

    lpfs_frame_checker #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_byte        (frame_byte),
        .byte_position     (byte_position),
        .frame_start       (frame_start),
        .frame_last        (frame_last),
        .length_error      (length_error),
        .declared_length   (declared_length),
        .mismatch_count    (mismatch_count),
        .pending_count     (pending_count),
        .bytes_checked     (bytes_checked),
        .frames_closed     (frames_closed),
        .length_errors_seen(length_errors_seen)
    );

    // receiver stall pattern, with a periodic long hold-off to fill the block
    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_cycle % HOLD_PERIOD == 300)
        begin
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                default:   out_stall <= rx_cycle[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d bytes still outstanding",
                     IDLE_LIMIT, pending_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_byte(input logic [lpfs_pkg::BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [31:0] len);
        int unsigned n;
        for (int i = 0; i < lpfs_pkg::HEADER_BYTES; i++)
            push_byte(len[8*i +: 8]);
        if (len > lpfs_pkg::HEADER_BYTES && len <= eff_max)
        begin
            n = len - lpfs_pkg::HEADER_BYTES;
            for (int unsigned i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_max_length(input logic [lpfs_pkg::CFG_W-1:0] v);
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_count != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eff_max = (v > MAX_BYTES) ? MAX_BYTES : v;
        cfg_writes++;
    endtask

    task automatic send_random_item();
        frame_kind_t kind;
        int          pick;
        int          n;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            kind = FRAME_GOOD;
        else if (pick < 80)
            kind = FRAME_BAD_LENGTH;
        else if (pick < 90)
            kind = FRAME_WILD_LENGTH;
        else
            kind = FRAME_NOISE;
        if (kind == FRAME_GOOD && eff_max < lpfs_pkg::HEADER_BYTES)
            kind = FRAME_BAD_LENGTH;
        case (kind)
            FRAME_GOOD:
            begin
                if ($urandom_range(0, 9) == 0)
                    send_frame((eff_max <= 64) ? eff_max : lpfs_pkg::HEADER_BYTES);
                else
                    send_frame($urandom_range(lpfs_pkg::HEADER_BYTES,
                                              (eff_max < 48) ? eff_max : 48));
            end
            FRAME_BAD_LENGTH:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_frame($urandom_range(0, lpfs_pkg::HEADER_BYTES - 1));
                else
                    send_frame(eff_max + 1);
            end
            FRAME_WILD_LENGTH:
                send_frame($urandom);
            default:
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial
    begin
        logic [lpfs_pkg::CFG_W-1:0] settings[8];
        int                         phase_start;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        data_byte   = '0;
        out_stall   = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        cfg_writes  = 0;
        idle_cycles = 0;
        rx_cycle    = 0;
        hold_left   = 0;
        mode_left   = 0;
        rx_mode     = RX_FREE;
        eff_max     = MAX_BYTES;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // header-only frame, lengths 0 and 3, shortest payload, one past the limit, all ones
        send_frame(32'd4);
        send_frame(32'd0);
        send_frame(32'd3);
        send_frame(32'd5);
        send_frame(32'd4097);
        send_frame(32'hFFFF_FFFF);

        settings = '{13'd8191, 13'd0, 13'd3, 13'd4, 13'd5, 13'd0, 13'd64, 13'd4096};
        settings[5] = 13'($urandom_range(6, 63));
        foreach (settings[i])
        begin
            write_max_length(settings[i]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_item();
        end

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("checked %0d bytes in %0d frames, %0d of them cut on a bad length",
                 bytes_checked, frames_closed, length_errors_seen);
        $display("%0d limit settings from 0 to the 13-bit ceiling, plus edge-case lengths",
                 cfg_writes);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: length_prefixed_frame_splitter.f
src/lpfs_pkg.sv
src/lpfs_cfg_reg.sv
src/lpfs_in_stage.sv
src/lpfs_deframer.sv
src/length_prefixed_frame_splitter.sv
tb/sv/lpfs_frame_checker.sv
tb/sv/tb_length_prefixed_frame_splitter.sv
